[rtl/lmcs_pkg.sv]
`default_nettype none

package lmcs_pkg;

  // input item opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // configuration register indexes
  localparam logic CFG_SLIDE_RATE = 1'b0;
  localparam logic CFG_MAP_LENGTH = 1'b1;

  // fixed geometry and timing
  localparam int unsigned ROWS_PER_MODULE = 8;
  localparam int unsigned ROW_W           = 3;
  localparam logic [15:0] TICK_MS         = 16'd10;
  localparam logic [7:0]  MAP_LENGTH_RST  = 8'd32;

  // one refresh walk: starting column offset and display length
  typedef struct packed {
    logic [7:0] offset;
    logic [7:0] len;
  } frame_t;

endpackage

`default_nettype wire

[rtl/lmcs_ram.sv]
`default_nettype none

module lmcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data while not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/lmcs_refresh.sv]
`default_nettype none

module lmcs_refresh #(
  parameter int unsigned MODULES     = 4,
  parameter int unsigned STORE_DEPTH = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire lmcs_pkg::frame_t               frame_i,
  output      logic                           busy_o,
  output      logic                           re_o,
  output      logic [$clog2(STORE_DEPTH)-1:0] raddr_o,
  input  wire logic [7:0]                     rdata_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [3:0]                     row_address_o,
  output      logic [7:0]                     segment_data_o,
  output      logic                           frame_end_o,
  output      logic                           last_o
);

  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned MODW = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int unsigned IDXW = 9;

  // walk state
  logic                          walk_q, walk_d;
  logic [lmcs_pkg::ROW_W-1:0]    row_q, row_d;
  logic [MODW-1:0]               mod_q, mod_d;
  lmcs_pkg::frame_t              frame_q, frame_d;

  // word whose read data sits in the ram output register
  logic                          pend_q, pend_d;
  logic [3:0]                    pend_row_q, pend_row_d;
  logic                          pend_fe_q, pend_fe_d;
  logic                          pend_last_q, pend_last_d;
  logic                          pend_zero_q, pend_zero_d;

  // output register
  logic                          ovalid_q, ovalid_d;
  logic [3:0]                    orow_q, orow_d;
  logic [7:0]                    odata_q, odata_d;
  logic                          ofe_q, ofe_d;
  logic                          olast_q, olast_d;

  logic                          move;
  logic                          issue;
  logic                          mod_zero;
  logic                          row_end;
  logic [IDXW-1:0]               idx_raw;
  logic [IDXW-1:0]               idx_adj;
  logic                          in_range;

  assign move     = pend_q && (!ovalid_q || out_ready_i);
  assign issue    = walk_q && (!pend_q || move);
  assign mod_zero = (mod_q == '0);
  assign row_end  = (row_q == lmcs_pkg::ROW_W'(lmcs_pkg::ROWS_PER_MODULE - 1));

  // store index with one conditional wrap
  always_comb begin
    idx_raw  = IDXW'(row_q) + (IDXW'(mod_q) << lmcs_pkg::ROW_W) + IDXW'(frame_q.offset);
    idx_adj  = (idx_raw >= IDXW'(frame_q.len)) ? idx_raw - IDXW'(frame_q.len) : idx_raw;
    in_range = (idx_adj < IDXW'(STORE_DEPTH));
  end

  assign re_o    = issue;
  assign raddr_o = idx_adj[AW-1:0];

  // walk over rows, and modules from the highest down
  always_comb begin
    walk_d  = walk_q;
    row_d   = row_q;
    mod_d   = mod_q;
    frame_d = frame_q;
    if (start_i) begin
      walk_d  = 1'b1;
      row_d   = '0;
      mod_d   = MODW'(MODULES - 1);
      frame_d = frame_i;
    end else if (issue) begin
      if (mod_zero) begin
        mod_d = MODW'(MODULES - 1);
        if (row_end) begin
          walk_d = 1'b0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        mod_d = mod_q - 1'b1;
      end
    end
  end

  // tags follow the read
  always_comb begin
    pend_d      = pend_q;
    pend_row_d  = pend_row_q;
    pend_fe_d   = pend_fe_q;
    pend_last_d = pend_last_q;
    pend_zero_d = pend_zero_q;
    if (issue) begin
      pend_d      = 1'b1;
      pend_row_d  = 4'(row_q) + 4'd1;
      pend_fe_d   = mod_zero;
      pend_last_d = mod_zero && row_end;
      pend_zero_d = !in_range;
    end else if (move) begin
      pend_d = 1'b0;
    end
  end

  // output beat register
  always_comb begin
    ovalid_d = ovalid_q;
    orow_d   = orow_q;
    odata_d  = odata_q;
    ofe_d    = ofe_q;
    olast_d  = olast_q;
    if (move) begin
      ovalid_d = 1'b1;
      orow_d   = pend_row_q;
      odata_d  = pend_zero_q ? 8'h00 : rdata_i;
      ofe_d    = pend_fe_q;
      olast_d  = pend_last_q;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q   <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      row_q    <= '0;
      mod_q    <= '0;
    end else begin
      walk_q   <= walk_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
      row_q    <= row_d;
      mod_q    <= mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q     <= frame_d;
    pend_row_q  <= pend_row_d;
    pend_fe_q   <= pend_fe_d;
    pend_last_q <= pend_last_d;
    pend_zero_q <= pend_zero_d;
    orow_q      <= orow_d;
    odata_q     <= odata_d;
    ofe_q       <= ofe_d;
    olast_q     <= olast_d;
  end

  assign busy_o         = walk_q || pend_q;
  assign out_valid_o    = ovalid_q;
  assign row_address_o  = orow_q;
  assign segment_data_o = odata_q;
  assign frame_end_o    = ofe_q;
  assign last_o         = olast_q;

endmodule

`default_nettype wire

[rtl/led_matrix_column_scroller.sv]
// a load, start or quiet tick gives no beat; a tick that fires a refresh gives MODULES*8
// beats, the first through the walk, read and output registers, then one beat per cycle
// while the receiver is ready, as the ram read port streams the column store
// the next item is taken when the last read word moves to the output, later on stalls
// reset: registers go to slide_rate 0, map_length 32, inactive; a clearing pass
// then zeroes every store address, during which no item is taken
`default_nettype none

module led_matrix_column_scroller #(
  parameter int unsigned MODULES     = 4,
  parameter int unsigned STORE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  column_addr_i,
  input  wire logic [7:0]  column_data_i,
  // result items
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [3:0]  row_address_o,
  output      logic [7:0]  segment_data_o,
  output      logic        frame_end_o,
  output      logic        last_o,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned AW      = $clog2(STORE_DEPTH);
  localparam logic [7:0]  MIN_LEN = 8'(MODULES * lmcs_pkg::ROWS_PER_MODULE);

  logic [15:0]       slide_rate_q;
  logic [7:0]        map_length_q;
  logic [7:0]        offset_q, offset_d;
  logic [15:0]       countdown_q, countdown_d;
  logic              active_q, active_d;
  logic              clr_q;
  logic [AW-1:0]     clr_addr_q;

  logic              accept;
  logic              busy;
  logic              fire;
  logic [15:0]       cd_dec;
  logic [15:0]       rate_neg;
  logic [15:0]       rate_mag;
  logic [7:0]        len;
  lmcs_pkg::frame_t  frame;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  assign in_ready_o = !clr_q && !busy;
  assign accept     = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slide_rate_q <= '0;
      map_length_q <= lmcs_pkg::MAP_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmcs_pkg::CFG_SLIDE_RATE: slide_rate_q <= cfg_data_i;
        lmcs_pkg::CFG_MAP_LENGTH: map_length_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // display length and reload magnitude
  always_comb begin
    len      = (map_length_q > MIN_LEN) ? map_length_q : MIN_LEN;
    rate_neg = 16'd0 - slide_rate_q;
    if (!slide_rate_q[15]) begin
      rate_mag = slide_rate_q;
    end else if (rate_neg[15]) begin
      rate_mag = 16'h7FFF;
    end else begin
      rate_mag = rate_neg;
    end
    cd_dec = countdown_q - lmcs_pkg::TICK_MS;
  end

  // item decode, countdown and offset step
  always_comb begin
    offset_d    = offset_q;
    countdown_d = countdown_q;
    active_d    = active_q;
    fire        = 1'b0;
    if (accept) begin
      unique case (opcode_i)
        lmcs_pkg::OP_START: begin
          active_d    = 1'b1;
          offset_d    = '0;
          countdown_d = '0;
        end
        lmcs_pkg::OP_TICK: begin
          if (active_q) begin
            if (!cd_dec[15] && (cd_dec != 16'd0)) begin
              countdown_d = cd_dec;
            end else begin
              countdown_d = rate_mag;
              fire        = 1'b1;
              if (slide_rate_q == 16'd0) begin
                active_d = 1'b0;
              end else if (slide_rate_q[15]) begin
                offset_d = (offset_q < len - 8'd1) ? offset_q + 8'd1 : 8'd0;
              end else begin
                offset_d = (offset_q != 8'd0) ? offset_q - 8'd1 : len - 8'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      countdown_q <= '0;
      active_q    <= 1'b0;
    end else begin
      offset_q    <= offset_d;
      countdown_q <= countdown_d;
      active_q    <= active_d;
    end
  end

  // clearing pass over the store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // store write port: clearing pass or column load
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = column_addr_i[AW-1:0];
    ram_wdata = column_data_i;
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = 8'h00;
    end else if (accept && (opcode_i == lmcs_pkg::OP_LOAD)
                 && ({1'b0, column_addr_i} < 9'(STORE_DEPTH))) begin
      ram_we = 1'b1;
    end
  end

  assign frame.offset = offset_q;
  assign frame.len    = len;

  lmcs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lmcs_refresh #(
    .MODULES     (MODULES),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_refresh (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (fire),
    .frame_i        (frame),
    .busy_o         (busy),
    .re_o           (ram_re),
    .raddr_o        (ram_raddr),
    .rdata_i        (ram_rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_address_o  (row_address_o),
    .segment_data_o (segment_data_o),
    .frame_end_o    (frame_end_o),
    .last_o         (last_o)
  );

`ifndef SYNTHESIS
  // no item is taken while the store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_ready_o)
    else $error("item taken during clearing pass");

  // a fired tick starts a refresh walk in the next cycle
  a_fire_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> busy)
    else $error("refresh did not start after fired tick");

  // loads never write the store while a refresh reads it
  a_no_write_in_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ram_we)
    else $error("store written during refresh");

  // read data is not dropped: the final beat carries the last row number
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (frame_end_o
      && (row_address_o == 4'(lmcs_pkg::ROWS_PER_MODULE))))
    else $error("final beat not on last row of module zero");
`endif

endmodule

`default_nettype wire

[sim/led_matrix_column_scroller_test.sv]
`timescale 1ns / 1ps

module led_matrix_column_scroller_test;
  import lmcs_pkg::*;

  localparam int MODULES         = 4;
  localparam int STORE_DEPTH     = 256;
  localparam int CLK_PERIOD      = 20;
  localparam int FRAME_BEATS     = MODULES * ROWS_PER_MODULE;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SUB_ITEMS       = 18;
  localparam int FROM_MODEL      = -1;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // one directed step: an input item or a register write
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [7:0]  data;
    int          typed_beats;
    logic [7:0]  typed_seg;
    logic        reg_idx;
    logic [15:0] reg_value;
  } stim_row_t;

  // how the beats of one accepted item are to be known
  typedef struct packed {
    int         typed_beats;
    logic [7:0] typed_seg;
  } check_plan_t;

  typedef struct packed {
    logic [3:0] row_address;
    logic [7:0] segment_data;
    logic       frame_end;
    logic       last_word;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = OP_LOAD;
  logic [7:0]  column_addr_i = 8'h00;
  logic [7:0]  column_data_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  row_address_o;
  logic [7:0]  segment_data_o;
  logic        frame_end_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_SLIDE_RATE;
  logic [15:0] cfg_data_i = 16'h0000;

  led_matrix_column_scroller #(
    .MODULES(MODULES),
    .STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .column_addr_i (column_addr_i),
    .column_data_i (column_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_address_o (row_address_o),
    .segment_data_o(segment_data_o),
    .frame_end_o   (frame_end_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // directed steps: extremes, each opcode, quiet and shrinking-length cases
  stim_row_t directed_tbl [0:25] = '{
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_UNUSED, 8'hFF, 8'hFF, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_START,  8'h00, 8'h00, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, 32,         8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_TICK,   8'hFF, 8'hFF, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_LOAD,   8'h00, 8'hFF, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_LOAD,   8'h1F, 8'h80, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_LOAD,   8'hFF, 8'h01, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_LOAD,   8'hAA, 8'h55, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_LOAD,   8'h55, 8'hAA, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_START,  8'hFF, 8'hFF, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, FROM_MODEL, 8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_CFG,  OP_LOAD,   8'h00, 8'h00, 0,          8'h00, CFG_MAP_LENGTH, 16'h00FF},
    '{ROW_CFG,  OP_LOAD,   8'h00, 8'h00, 0,          8'h00, CFG_SLIDE_RATE, 16'h000A},
    '{ROW_ITEM, OP_START,  8'h00, 8'h00, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, FROM_MODEL, 8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, FROM_MODEL, 8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_CFG,  OP_LOAD,   8'h00, 8'h00, 0,          8'h00, CFG_MAP_LENGTH, 16'h0020},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, FROM_MODEL, 8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_CFG,  OP_LOAD,   8'h00, 8'h00, 0,          8'h00, CFG_SLIDE_RATE, 16'hFFFF},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, FROM_MODEL, 8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_CFG,  OP_LOAD,   8'h00, 8'h00, 0,          8'h00, CFG_MAP_LENGTH, 16'h0000},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, FROM_MODEL, 8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_CFG,  OP_LOAD,   8'h00, 8'h00, 0,          8'h00, CFG_SLIDE_RATE, 16'h8000},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, FROM_MODEL, 8'h00, CFG_SLIDE_RATE, 16'h0000},
    '{ROW_ITEM, OP_TICK,   8'h00, 8'h00, 0,          8'h00, CFG_SLIDE_RATE, 16'h0000}
  };

  // scroller state as the testbench sees it
  logic [7:0]         col_mem [STORE_DEPTH];
  logic [7:0]         scroll_pos;
  logic [15:0]        tick_countdown;
  logic               scrolling;
  logic signed [15:0] rate_reg;
  logic [7:0]         len_reg;
  beat_t              frame_buf [FRAME_BEATS];

  beat_t       expected_beats [$];
  check_plan_t check_plans [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  function automatic int view_len();
    return (int'(len_reg) > FRAME_BEATS) ? int'(len_reg) : FRAME_BEATS;
  endfunction

  // apply one accepted item to the scroller state, fill frame_buf
  task automatic scroll_step(input logic [1:0] op, input logic [7:0] addr,
                             input logic [7:0] data, output int n);
    int len;
    int idx;
    int mag;
    n = 0;
    case (op)
      OP_LOAD: begin
        col_mem[addr] = data;
      end
      OP_START: begin
        scrolling      = 1'b1;
        scroll_pos     = 8'h00;
        tick_countdown = 16'h0000;
      end
      OP_TICK: begin
        if (scrolling) begin
          tick_countdown = tick_countdown - TICK_MS;
          if ($signed(tick_countdown) <= 0) begin
            mag = rate_reg;
            if (mag < 0) mag = -mag;
            if (mag > 32767) mag = 32767;
            tick_countdown = mag[15:0];
            len = view_len();
            // rows ascending, modules from the far end down to module 0
            for (int row = 1; row <= ROWS_PER_MODULE; row++) begin
              for (int m = MODULES - 1; m >= 0; m--) begin
                idx = row - 1 + m * ROWS_PER_MODULE + int'(scroll_pos);
                if (idx >= len) idx -= len;
                frame_buf[n].row_address  = row[3:0];
                frame_buf[n].segment_data = (idx < STORE_DEPTH) ? col_mem[idx] : 8'h00;
                frame_buf[n].frame_end    = (m == 0);
                frame_buf[n].last_word    = (m == 0) && (row == ROWS_PER_MODULE);
                n++;
              end
            end
            // step the window in the direction of the rate sign
            if (rate_reg == 0) begin
              scrolling = 1'b0;
            end else if (rate_reg < 0) begin
              scroll_pos = (int'(scroll_pos) < len - 1) ? scroll_pos + 8'd1 : 8'd0;
            end else begin
              scroll_pos = (scroll_pos > 0) ? scroll_pos - 8'd1 : 8'(len - 1);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // register writes and accepted beats on both channels
  always @(posedge clk_i) begin : scoreboard
    check_plan_t plan;
    beat_t       want;
    int          n;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SLIDE_RATE) rate_reg = cfg_data_i;
        else len_reg = cfg_data_i[7:0];
      end
      if (in_valid_i && in_ready_o) begin
        plan = check_plans.pop_front();
        scroll_step(opcode_i, column_addr_i, column_data_i, n);
        if (plan.typed_beats == FROM_MODEL) begin
          for (int k = 0; k < n; k++) expected_beats.push_back(frame_buf[k]);
        end else begin
          for (int k = 0; k < plan.typed_beats; k++) begin
            want.row_address  = 4'(k / MODULES + 1);
            want.segment_data = plan.typed_seg;
            want.frame_end    = (k % MODULES) == MODULES - 1;
            want.last_word    = (k == plan.typed_beats - 1);
            expected_beats.push_back(want);
          end
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: row_address %0d segment_data %0h",
                 row_address_o, segment_data_o);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          if (row_address_o !== want.row_address) begin
            $error("row_address: expected %0d, got %0d", want.row_address, row_address_o);
            mismatch_count++;
          end
          if (segment_data_o !== want.segment_data) begin
            $error("segment_data: expected %0h, got %0h", want.segment_data, segment_data_o);
            mismatch_count++;
          end
          if (frame_end_o !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end_o);
            mismatch_count++;
          end
          if (last_o !== want.last_word) begin
            $error("last: expected %0b, got %0b", want.last_word, last_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[led_matrix_column_scroller] ERROR");
      $finish;
    end
  end

  // offer one item, hold it until accepted
  task automatic send_beat(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] data, input int typed_beats,
                           input logic [7:0] typed_seg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    check_plans.push_back('{typed_beats, typed_seg});
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    column_addr_i <= addr;
    column_data_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold off input until every beat is back
  task automatic drain_frames();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic idx, input logic [15:0] value);
    drain_frames();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int          send_idle [4];
    int          recv_stall [4];
    int          pause_at;
    int          sent;
    int          pick;
    int          mag;
    logic [15:0] rate_val;
    logic [7:0]  len_val;
    logic [1:0]  op;
    logic [7:0]  addr;

    send_idle  = '{0, 88, 0, 27};
    recv_stall = '{0, 0, 88, 27};

    // reset state of the scroller
    foreach (col_mem[i]) col_mem[i] = 8'h00;
    scroll_pos     = 8'h00;
    tick_countdown = 16'h0000;
    scrolling      = 1'b0;
    rate_reg       = 16'sh0000;
    len_reg        = MAP_LENGTH_RST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed steps
    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].kind == ROW_CFG) begin
        write_reg(directed_tbl[i].reg_idx, directed_tbl[i].reg_value);
      end else begin
        send_beat(directed_tbl[i].op, directed_tbl[i].addr, directed_tbl[i].data,
                  directed_tbl[i].typed_beats, directed_tbl[i].typed_seg);
      end
    end

    // random phases, each with its own idling mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_idle[p];
      stall_pct     = recv_stall[p];
      pause_at      = $urandom_range(0, 3 * SUB_ITEMS - 1);
      sent          = 0;
      for (int s = 0; s < 3; s++) begin
        // new rate and length, extremes now and then
        case ($urandom_range(0, 9))
          0: rate_val = 16'h0000;
          1: rate_val = 16'h8000;
          2: rate_val = 16'h7FFF;
          3: rate_val = 16'($urandom_range(0, 65535));
          default: begin
            mag      = $urandom_range(1, 40);
            rate_val = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
          end
        endcase
        case ($urandom_range(0, 5))
          0: len_val = 8'd0;
          1: len_val = 8'd255;
          2: len_val = 8'd1;
          3: len_val = 8'($urandom_range(0, 255));
          default: len_val = 8'($urandom_range(32, 64));
        endcase
        write_reg(CFG_SLIDE_RATE, rate_val);
        write_reg(CFG_MAP_LENGTH, {8'h00, len_val});

        // a start, then mostly ticks, with loads, further starts and some unused opcodes mixed in
        for (int n = 0; n < SUB_ITEMS; ) begin
          pick = (n == 0) ? 40 : $urandom_range(0, 99);
          addr = 8'($urandom_range(0, 255));
          if (pick < 30) begin
            op = OP_LOAD;
            if ($urandom_range(0, 3) != 0) addr = 8'($urandom_range(0, view_len() - 1));
          end else if (pick < 36) begin
            op = OP_UNUSED;
          end else if (pick < 42) begin
            op = OP_START;
          end else begin
            op = OP_TICK;
          end
          send_beat(op, addr, 8'($urandom_range(0, 255)), FROM_MODEL, 8'h00);
          if (op != OP_UNUSED) begin
            n++;
            if (sent == pause_at) drain_frames();
            sent++;
          end
        end
      end
    end

    // wait out the last frames
    drain_frames();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("[led_matrix_column_scroller] OK");
    end else begin
      $display("[led_matrix_column_scroller] ERROR");
    end
    $finish;
  end

endmodule
